// File: rtl/core/cmfr_pkg.sv
// Shared types and constants for the CAN multi-frame reassembler.
package cmfr_pkg;

  localparam int SLOT_IDX_W = 4;
  localparam int COUNT_W = 9;
  localparam int LANES = 8;
  localparam logic [7:0] OWN_ADDR_RESET = 8'h20;
  localparam logic [7:0] MAGIC_B0 = 8'hAF;
  localparam logic [7:0] MAGIC_B1 = 8'hCB;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_BEGIN  = 2'd1,
    KIND_MIDDLE = 2'd2,
    KIND_FINISH = 2'd3
  } frame_kind_t;

  typedef struct packed {
    logic [7:0]  target_addr;
    logic [7:0]  source_addr;
    frame_kind_t frame_kind;
    logic [3:0]  byte_count;
    logic [63:0] frame_data;
  } cmfr_frame_t;

  typedef struct packed {
    logic [7:0]  out_source;
    logic [63:0] out_word;
    logic [3:0]  out_bytes;
    logic        out_last;
  } cmfr_beat_t;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot;
    logic [7:0]            src;
    logic [COUNT_W-1:0]    wr_off;
    logic [3:0]            wr_len;
    logic [63:0]           wr_data;
    logic                  emit;
    logic [COUNT_W-1:0]    total;
  } cmfr_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WRITE,
    BK_FETCH,
    BK_SEND
  } back_state_t;

endpackage

// File: rtl/core/cmfr_front.sv
// Front end: address filter, slot lookup and bookkeeping, command generation.
module cmfr_front import cmfr_pkg::*; #(
  parameter int SLOTS = 4,
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        frame_valid,
  output logic        frame_ready,
  input  cmfr_frame_t frame,
  input  logic        q_full,
  output logic        push,
  output cmfr_cmd_t   cmd
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

  logic [7:0]       own_address;
  logic [7:0]       slot_source [SLOTS];
  logic [CNT_W-1:0] slot_count [SLOTS];
  // Copies of buffer bytes 0 and 1 per slot, used for the header check.
  logic [7:0]       slot_b0 [SLOTS];
  logic [7:0]       slot_b1 [SLOTS];

  logic [SLOTS-1:0] match_vec;
  logic [SLOTS-1:0] free_vec;
  logic             hit;
  logic             free_any;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] sel;
  logic             accept;
  logic             for_us;
  logic             usable;
  logic             claim;
  logic             is_start;
  logic             fits;
  logic             do_write;
  logic [3:0]       len;
  logic [CNT_W-1:0] cur_count;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] wr_off;
  logic [CNT_W-1:0] new_total;
  logic [7:0]       new_b0;
  logic [7:0]       new_b1;
  logic             magic;
  logic             emit;

  assign frame_ready = !q_full;
  assign accept = frame_valid && frame_ready;
  assign for_us = frame.target_addr == own_address;

  always_comb begin
    hit = 1'b0;
    free_any = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match_vec[i] = slot_source[i] == frame.source_addr;
      free_vec[i] = slot_source[i] == 8'd0;
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (free_vec[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    sel = hit ? hit_idx : free_idx;
    claim = !hit && free_any;
    usable = for_us && (hit || free_any);
    len = (frame.byte_count > 4'd8) ? 4'd8 : frame.byte_count;
    is_start = frame.frame_kind inside {KIND_SINGLE, KIND_BEGIN};
    cur_count = slot_count[sel];
    sum = {1'b0, cur_count} + (CNT_W + 1)'(len);
    fits = sum <= (CNT_W + 1)'(BUFFER_BYTES);
    do_write = usable && (is_start || fits);
    wr_off = is_start ? '0 : cur_count;
    new_total = is_start ? CNT_W'(len) : sum[CNT_W-1:0];

    // A start frame zeroes the header copies of bytes it does not load.
    if (wr_off == '0 && len != 4'd0) begin
      new_b0 = frame.frame_data[7:0];
    end else if (is_start) begin
      new_b0 = 8'd0;
    end else begin
      new_b0 = slot_b0[sel];
    end
    if (wr_off == '0 && len > 4'd1) begin
      new_b1 = frame.frame_data[15:8];
    end else if (wr_off == CNT_W'(1) && len != 4'd0) begin
      new_b1 = frame.frame_data[7:0];
    end else if (is_start) begin
      new_b1 = 8'd0;
    end else begin
      new_b1 = slot_b1[sel];
    end

    magic = new_b0 == MAGIC_B0 && new_b1 == MAGIC_B1;
    emit = do_write && magic && new_total != '0 &&
           (frame.frame_kind == KIND_SINGLE || frame.frame_kind == KIND_FINISH);
    push = accept && do_write && (len != 4'd0 || emit);

    cmd.slot = SLOT_IDX_W'(sel);
    cmd.src = frame.source_addr;
    cmd.wr_off = COUNT_W'(wr_off);
    cmd.wr_len = len;
    cmd.wr_data = frame.frame_data;
    cmd.emit = emit;
    cmd.total = COUNT_W'(new_total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= OWN_ADDR_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        slot_source[i] <= 8'd0;
        slot_count[i] <= '0;
        slot_b0[i] <= 8'd0;
        slot_b1[i] <= 8'd0;
      end
    end else begin
      if (cfg_wr_en) begin
        own_address <= cfg_wr_data;
      end
      if (accept && usable) begin
        // A finish that lands frees the slot, even one it has just claimed.
        if (do_write && frame.frame_kind == KIND_FINISH) begin
          slot_source[sel] <= 8'd0;
        end else if (claim) begin
          slot_source[sel] <= frame.source_addr;
        end
        if (do_write) begin
          slot_b0[sel] <= new_b0;
          slot_b1[sel] <= new_b1;
          if (frame.frame_kind == KIND_FINISH) begin
            slot_count[sel] <= '0;
          end else begin
            slot_count[sel] <= new_total;
          end
        end
      end
    end
  end

  // Nonzero sources are claimed only when unmatched, so at most one slot holds each.
  a_unique_source: assert property (@(posedge clk) disable iff (rst)
    (frame.source_addr != 8'd0) |-> $onehot0(match_vec))
    else $error("two slots hold the same source address");

endmodule

// File: rtl/core/cmfr_queue.sv
// Two-entry command queue between the front end and the back end.
module cmfr_queue import cmfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmfr_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output cmfr_cmd_t head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  cmfr_cmd_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign full = fill == (PTR_W + 1)'(DEPTH);
  assign empty = fill == '0;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PTR_W + 1)'(1);
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop) && !(pop && empty))
    else $error("command queue overrun or underrun");

endmodule

// File: rtl/core/cmfr_back.sv
// Back end: slot buffer memories, frame writes and message beat streaming.
module cmfr_back import cmfr_pkg::*; #(
  parameter int SLOTS = 4,
  parameter int BUFFER_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmfr_cmd_t  q_head,
  output logic       q_pop,
  output logic       beat_valid,
  input  logic       beat_ready,
  output cmfr_beat_t beat
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int ROWS = (BUFFER_BYTES + LANES - 1) / LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int MEM_DEPTH = SLOTS * ROWS;
  localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  back_state_t      state;
  back_state_t      state_next;
  cmfr_cmd_t        cur;
  logic [CNT_W-1:0] rem;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] rd_row_sel;
  logic [ADDR_W-1:0] slot_base;
  logic [ADDR_W-1:0] rd_addr;
  logic             rd_en;
  logic             last;
  logic [3:0]       take;
  logic             beat_done;

  assign slot_base = ADDR_W'(cur.slot[SLOT_W-1:0]) * ADDR_W'(ROWS);
  assign last = rem <= CNT_W'(LANES);
  assign take = last ? rem[3:0] : 4'(LANES);
  assign beat_done = beat_valid && beat_ready;

  // Byte n of the buffer lives in lane n mod 8, row n / 8, so all bytes of one
  // frame are written in the same cycle even when it straddles two rows.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [7:0]         mem [MEM_DEPTH];
    logic [7:0]         lane_rd;
    logic [2:0]         lane_j;
    logic [COUNT_W-1:0] lane_pos;
    logic               lane_we;
    logic [ADDR_W-1:0]  lane_waddr;

    assign lane_j = 3'(l) - cur.wr_off[2:0];
    assign lane_pos = cur.wr_off + COUNT_W'(lane_j);
    assign lane_we = state == BK_WRITE && {1'b0, lane_j} < cur.wr_len;
    assign lane_waddr = slot_base + ADDR_W'(lane_pos[ROW_W+2:3]);

    always_ff @(posedge clk) begin
      if (lane_we) begin
        mem[lane_waddr] <= cur.wr_data[8*lane_j +: 8];
      end
      if (rd_en) begin
        lane_rd <= mem[rd_addr];
      end
    end

    assign beat.out_word[8*l +: 8] = (4'(l) < take) ? lane_rd : 8'd0;
  end

  assign beat.out_source = cur.src;
  assign beat.out_bytes = take;
  assign beat.out_last = last;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) state_next = BK_WRITE;
      end
      BK_WRITE: begin
        state_next = cur.emit ? BK_FETCH : BK_IDLE;
      end
      BK_FETCH: begin
        state_next = BK_SEND;
      end
      BK_SEND: begin
        if (beat_ready && last) state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    rd_en = 1'b0;
    beat_valid = 1'b0;
    rd_row_sel = rd_row;
    case (state)
      BK_IDLE: begin
        q_pop = !q_empty;
      end
      BK_FETCH: begin
        rd_en = 1'b1;
      end
      BK_SEND: begin
        beat_valid = 1'b1;
        // Fetch the next row as the current beat leaves.
        rd_en = beat_ready && !last;
        rd_row_sel = rd_row + ROW_W'(1);
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign rd_addr = slot_base + ADDR_W'(rd_row_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (state == BK_WRITE) begin
      rem <= cur.total[CNT_W-1:0];
      rd_row <= '0;
    end else if (beat_done) begin
      rem <= rem - CNT_W'(LANES);
      rd_row <= rd_row + ROW_W'(1);
    end
  end

  a_beat_nonempty: assert property (@(posedge clk) disable iff (rst)
    beat_valid |-> rem != '0)
    else $error("beat offered with no bytes left");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (beat_done && last) |=> !beat_valid)
    else $error("beats continue after the final beat");

  a_pop_writes: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == BK_WRITE && !beat_valid)
    else $error("popped request not written next cycle");

endmodule

// File: rtl/core/can_multi_frame_reassembler_core.sv
// Top level of the CAN multi-frame reassembler.
//
// Frames come in on frame_valid/frame_ready with their target, source, kind,
// byte count and data. A frame whose target differs from own_address is taken
// and ignored. cfg_wr_en writes own_address from cfg_wr_data.
// Each accepted frame for own_address that finds a matching or free slot
// updates the slot table at once and, when it carries bytes or completes a
// message, is queued for the back end. The back end pops each queued request
// and writes it into the slot buffer, all byte lanes in the same cycle. A
// completed message with the 0xAF 0xCB header follows on beat_valid/beat_ready
// one 8-byte beat per cycle while beat_ready is high (up to 32 beats);
// beat_valid rises after the queue and the IDLE, WRITE and FETCH states.
// The two-entry request queue lets frames keep arriving while beats stall;
// frame_ready drops only when the queue is full. A stalled beat holds its
// value until taken. Reset frees all slots, sets own_address to 0x20 and
// empties the queue; the buffer memories need no clearing.
module can_multi_frame_reassembler_core import cmfr_pkg::*; #(
  parameter int SLOTS = 4,
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        frame_valid,
  output logic        frame_ready,
  input  cmfr_frame_t frame,
  output logic        beat_valid,
  input  logic        beat_ready,
  output cmfr_beat_t  beat
);

  logic      push;
  cmfr_cmd_t push_cmd;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  cmfr_cmd_t q_head;

  cmfr_front #(
    .SLOTS(SLOTS),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .frame_valid(frame_valid),
    .frame_ready(frame_ready),
    .frame(frame),
    .q_full(q_full),
    .push(push),
    .cmd(push_cmd)
  );

  cmfr_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_cmd(push_cmd),
    .full(q_full),
    .pop(q_pop),
    .empty(q_empty),
    .head(q_head)
  );

  cmfr_back #(
    .SLOTS(SLOTS),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_head(q_head),
    .q_pop(q_pop),
    .beat_valid(beat_valid),
    .beat_ready(beat_ready),
    .beat(beat)
  );

endmodule
